// ----- design/multi_region_bump_allocator_core_assert.svh -----
// Assertion macros shared by the bump allocator RTL
`ifndef MULTI_REGION_BUMP_ALLOCATOR_CORE_ASSERT_SVH
`define MULTI_REGION_BUMP_ALLOCATOR_CORE_ASSERT_SVH

// Condition must hold in the same cycle as the antecedent
`define MRBA_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition must hold in the cycle after the antecedent
`define MRBA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Expression must never be true
`define MRBA_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);

`endif

// ----- design/mrba_pkg.sv -----
// Shared constants, codes and types of the bump allocator
`timescale 1ns / 1ps

package mrba_pkg;

   localparam int REGIONS      = 4;
   localparam int HEADER_BYTES = 32;
   localparam int ADDR_BITS    = 48;
   localparam int SIZE_BITS    = 32;
   localparam int CNT_BITS     = $clog2(REGIONS + 1);

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BAD_ARG = 2'd1;
   localparam logic [1:0] STATUS_NO_ROOM = 2'd2;
   localparam logic [1:0] STATUS_FULL    = 2'd3;

   localparam logic MODE_ADD   = 1'b0;
   localparam logic MODE_ALLOC = 1'b1;

   typedef struct packed {
      logic                 mode;
      logic [ADDR_BITS-1:0] region_base;
      logic [ADDR_BITS-1:0] region_len;
      logic [SIZE_BITS-1:0] alloc_size;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [ADDR_BITS-1:0] address;
   } rsp_type;

   // One region as a cell holds it: next free byte and bytes left
   typedef struct packed {
      logic [ADDR_BITS-1:0] cursor;
      logic [ADDR_BITS-1:0] room;
   } entry_type;

   // Search token handed from cell to cell
   typedef struct packed {
      logic                 tok;
      logic [SIZE_BITS-1:0] size;
   } token_type;

   typedef struct packed {
      logic                 hit;
      logic                 miss;
      logic [ADDR_BITS-1:0] address;
   } cell_res_type;

endpackage

// ----- design/mrba_cell.sv -----
// One region cell of the allocator chain
`timescale 1ns / 1ps
`include "multi_region_bump_allocator_core_assert.svh"

module mrba_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  valid,
   input  logic                  shift_en,
   input  mrba_pkg::entry_type    shift_in,
   output mrba_pkg::entry_type    shift_out,
   input  mrba_pkg::token_type    tok_in,
   output mrba_pkg::token_type    tok_out,
   output mrba_pkg::cell_res_type res
);
   import mrba_pkg::*;

   logic [ADDR_BITS-1:0] cursor_ff, cursor_in;
   logic [ADDR_BITS-1:0] room_ff, room_in;
   logic                 tok_ff;
   logic [SIZE_BITS-1:0] size_ff;
   logic [ADDR_BITS-1:0] size_ext;
   logic                 fit;
   logic                 hit;
   // modulo the address space: a region ending at the top byte sums to zero
   logic [ADDR_BITS-1:0] span;

   assign size_ext = {{(ADDR_BITS - SIZE_BITS){1'b0}}, size_ff};
   assign fit      = size_ext <= room_ff;
   assign hit      = tok_ff & valid & fit;
   assign span     = cursor_ff + room_ff;

   assign res.hit     = hit;
   assign res.miss    = tok_ff & ~valid;
   assign res.address = hit ? cursor_ff : '0;

   // pass the search on when this region cannot serve it
   assign tok_out.tok  = tok_ff & valid & ~fit;
   assign tok_out.size = size_ff;

   assign shift_out.cursor = cursor_ff;
   assign shift_out.room   = room_ff;

   always_comb begin
      cursor_in = cursor_ff;
      room_in   = room_ff;
      if (shift_en) begin
         cursor_in = shift_in.cursor;
         room_in   = shift_in.room;
      end else if (hit) begin
         cursor_in = cursor_ff + size_ext;
         room_in   = room_ff - size_ext;
      end
   end

   always_ff @(posedge clock) begin
      cursor_ff <= cursor_in;
      room_ff   <= room_in;
      size_ff   <= tok_in.size;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= 1'b0;
      end else begin
         tok_ff <= tok_in.tok;
      end
   end

   `MRBA_ASSERT_NEVER(a_no_shift_in_search, clock, reset, shift_en && tok_ff, "shift during search")
   `MRBA_ASSERT_NEXT(a_span_kept, clock, reset, hit, span == $past(span), "region end moved")
   `MRBA_ASSERT_IMPL(a_cursor_nonzero, clock, reset, hit, cursor_ff != '0, "zero address handed out")

endmodule

// ----- design/multi_region_bump_allocator_core.sv -----
// Top level of the multi-region bump allocator
//
//   channel  direction  ports                          payload
//   request  in         req_valid, req_stall, req_data  mode, region_base, region_len, alloc_size
//   response out        rsp_valid, rsp_stall, rsp_data  status, address
//
// An add, or an allocate of zero bytes, passes through EXEC and DONE before the next request.
// An allocate stays in SRCH until a cell hits or the token misses, then passes DONE: the search
// token steps one cell per cycle through the chain, newest region first.
// Reset is synchronous and empties the region table; region contents are not cleared.
// A stalled response sits in its output register while the next request is taken.
`timescale 1ns / 1ps
`include "multi_region_bump_allocator_core_assert.svh"

module multi_region_bump_allocator_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mrba_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mrba_pkg::rsp_type rsp_data
);
   import mrba_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_SRCH = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   localparam logic [ADDR_BITS-1:0] HDR = ADDR_BITS'(HEADER_BYTES);

   logic [1:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   req_type             req_ff;
   rsp_type             res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff;

   logic                accept;
   logic                out_free;
   logic                add_ok;
   logic                shift_en;
   logic                base_nz;
   logic                len_ok;
   logic [ADDR_BITS:0]  last_byte;
   logic                over;
   logic                table_full;

   entry_type           new_entry;
   token_type           launch;
   entry_type           cell_entry [REGIONS];
   token_type           cell_tok   [REGIONS];
   cell_res_type        cell_res   [REGIONS];
   logic [REGIONS-1:0]  area_valid;
   logic [REGIONS-1:0]  hit_vec;
   logic [REGIONS-1:0]  miss_vec;
   logic                any_hit;
   logic                any_miss;
   logic [ADDR_BITS-1:0] hit_addr;

   // take a request only when the previous result has moved to the output register
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;

   // add checks: nonzero base, room for the header, last byte inside the address space, a free slot
   assign base_nz    = |req_ff.region_base;
   assign len_ok     = req_ff.region_len > HDR;
   assign last_byte  = {1'b0, req_ff.region_base} + {1'b0, req_ff.region_len}
                       - (ADDR_BITS + 1)'(1);
   assign over       = last_byte[ADDR_BITS];
   assign table_full = (count_ff >= CNT_BITS'(REGIONS));
   assign add_ok     = (state_ff == S_EXEC) && (req_ff.mode == MODE_ADD) &&
                       base_nz && len_ok && !over && !table_full;
   assign shift_en   = add_ok;

   assign new_entry.cursor = req_ff.region_base + HDR;
   assign new_entry.room   = req_ff.region_len - HDR;

   // launch the search token into the newest cell at the request transfer
   assign launch.tok  = accept && (req_data.mode == MODE_ALLOC) && (|req_data.alloc_size);
   assign launch.size = req_data.alloc_size;

   // cell k holds the k-th newest region; an add shifts every region one cell on
   for (genvar k = 0; k < REGIONS; k++) begin : g_cell
      entry_type sin;
      token_type tin;

      assign area_valid[k] = count_ff > CNT_BITS'(k);

      if (k == 0) begin : g_head
         assign sin = new_entry;
         assign tin = launch;
      end else begin : g_body
         assign sin = cell_entry[k-1];
         assign tin = cell_tok[k-1];
      end

      mrba_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .valid     (area_valid[k]),
         .shift_en  (shift_en),
         .shift_in  (sin),
         .shift_out (cell_entry[k]),
         .tok_in    (tin),
         .tok_out   (cell_tok[k]),
         .res       (cell_res[k])
      );

      assign hit_vec[k]  = cell_res[k].hit;
      assign miss_vec[k] = cell_res[k].miss;
   end

   // at most one cell holds the token, so an OR picks its address
   always_comb begin
      hit_addr = '0;
      for (int k = 0; k < REGIONS; k++) begin
         hit_addr = hit_addr | cell_res[k].address;
      end
   end

   assign any_hit  = |hit_vec;
   // the token falling off the oldest cell is a miss as well
   assign any_miss = (|miss_vec) | cell_tok[REGIONS-1].tok;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = launch.tok ? S_SRCH : S_EXEC;
            end
         end
         S_EXEC: begin
            res_in.address = '0;
            if (req_ff.mode == MODE_ALLOC) begin
               res_in.status = STATUS_BAD_ARG;
            end else if (!base_nz || !len_ok || over) begin
               res_in.status = STATUS_BAD_ARG;
            end else if (table_full) begin
               res_in.status = STATUS_FULL;
            end else begin
               res_in.status = STATUS_OK;
               count_in      = count_ff + CNT_BITS'(1);
            end
            state_in = S_DONE;
         end
         S_SRCH: begin
            if (any_hit) begin
               res_in.status  = STATUS_OK;
               res_in.address = hit_addr;
               state_in       = S_DONE;
            end else if (any_miss) begin
               res_in.status  = STATUS_NO_ROOM;
               res_in.address = '0;
               state_in       = S_DONE;
            end
         end
         S_DONE: begin
            // hold the result until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      res_ff <= res_in;
      if ((state_ff == S_DONE) && out_free) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `MRBA_ASSERT_NEVER(a_count_bound, clock, reset, count_ff > CNT_BITS'(REGIONS), "region count overflow")
   `MRBA_ASSERT_NEVER(a_single_hit, clock, reset, !$onehot0(hit_vec), "more than one cell hit")
   `MRBA_ASSERT_IMPL(a_search_only, clock, reset, state_ff != S_SRCH, !any_hit && !(|miss_vec), "cell active outside search")
   `MRBA_ASSERT_NEXT(a_add_counts, clock, reset, add_ok, count_ff == $past(count_ff) + CNT_BITS'(1), "add not counted")

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench of the multi-region bump allocator core
`timescale 1ns / 1ps

module testbench;
   import mrba_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 500;
   localparam int TAIL_CYCLES  = 20;

   // One line of the directed plan: the request, and where the outcome is
   // obvious, the outcome typed in by hand
   typedef struct {
      req_type req;
      bit      fixed;
      rsp_type outcome;
   } plan_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Shadow of the region table, kept 64 bits wide so that no sum wraps
   logic [63:0] region_first [REGIONS];
   logic [63:0] region_last  [REGIONS];
   logic [63:0] region_taken [REGIONS];
   int          region_total = 0;

   rsp_type      pending_outcomes [$];
   plan_row_type plan [$];
   rsp_type      oldest;
   int           mismatches  = 0;
   int           sent        = 0;
   int           cycles      = 0;
   int           stall_hold  = 0;
   bit           calm        = 1'b0;

   multi_region_bump_allocator_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Give up on a hung block: a correct run finishes far inside this
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   task automatic report(input string msg);
      $display("mismatch after %0d transfers: %s", sent, msg);
      mismatches++;
   endtask

   // Work out the outcome of one request and advance the shadow table.
   // An add is checked for a zero base, a length that leaves no usable byte
   // and a last byte past the address space before the table-full check.
   // An allocate walks the regions newest first and takes the first fit.
   function automatic rsp_type allocator_outcome(input req_type r);
      logic [63:0] base;
      logic [63:0] len;
      logic [63:0] size;
      logic [63:0] span;
      logic [63:0] top;
      rsp_type     o;
      int          i;
      top       = (64'd1 << ADDR_BITS) - 64'd1;
      base      = 64'(r.region_base);
      len       = 64'(r.region_len);
      size      = 64'(r.alloc_size);
      o.status  = STATUS_OK;
      o.address = '0;
      if (r.mode == MODE_ADD) begin
         if (base == 64'd0 || len <= 64'(HEADER_BYTES)) begin
            o.status = STATUS_BAD_ARG;
         end else if (len - 64'd1 > top - base) begin
            o.status = STATUS_BAD_ARG;
         end else if (region_total >= REGIONS) begin
            o.status = STATUS_FULL;
         end else begin
            region_first[region_total] = base + 64'(HEADER_BYTES);
            region_last[region_total]  = base + len - 64'd1;
            region_taken[region_total] = 64'd0;
            region_total++;
         end
      end else if (size == 64'd0) begin
         o.status = STATUS_BAD_ARG;
      end else begin
         o.status = STATUS_NO_ROOM;
         for (i = region_total - 1; i >= 0; i--) begin
            span = region_last[i] - region_first[i];
            // Skip a spent region, then test the fit without any wrap
            if (o.status == STATUS_NO_ROOM && region_taken[i] <= span &&
                size - 64'd1 <= span - region_taken[i]) begin
               o.status        = STATUS_OK;
               o.address       = ADDR_BITS'(region_first[i] + region_taken[i]);
               region_taken[i] = region_taken[i] + size;
            end
         end
      end
      return o;
   endfunction

   function automatic plan_row_type plan_row(input logic mode,
                                             input logic [ADDR_BITS-1:0] base,
                                             input logic [ADDR_BITS-1:0] len,
                                             input logic [SIZE_BITS-1:0] size,
                                             input bit fixed,
                                             input logic [1:0] status,
                                             input logic [ADDR_BITS-1:0] address);
      plan_row_type p;
      p.req.mode           = mode;
      p.req.region_base    = base;
      p.req.region_len     = len;
      p.req.alloc_size     = size;
      p.fixed              = fixed;
      p.outcome.status     = status;
      p.outcome.address    = address;
      return p;
   endfunction

   // Offer one request: idle for a drawn gap, hold it until the transfer,
   // then queue its expected outcome. Valid stays high into a gap-free next
   // request, so it gets a single update per edge.
   task automatic offer(input req_type r, input bit fixed, input rsp_type typed);
      int      gap;
      rsp_type model;
      gap = calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // Step the shadow table even where the outcome is typed in
      model = allocator_outcome(r);
      pending_outcomes.push_back(fixed ? typed : model);
      sent++;
      // Every fourth stretch of 40 transfers runs with no idling on either side
      calm = ((sent / 40) % 4) == 3;
   endtask

   // Response side: check each transfer against the oldest expectation and
   // draw how long to stall before the next one
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            report($sformatf("result with nothing pending: status %0d address %h",
                             rsp_data.status, rsp_data.address));
         end else begin
            oldest = pending_outcomes.pop_front();
            if (rsp_data.status !== oldest.status)
               report($sformatf("status %0d, expected %0d",
                                rsp_data.status, oldest.status));
            if (rsp_data.address !== oldest.address)
               report($sformatf("address %h, expected %h",
                                rsp_data.address, oldest.address));
         end
         stall_hold = calm ? 0 : $urandom_range(0, 8);
      end
      if (stall_hold > 0) begin
         rsp_stall <= 1'b1;
         stall_hold--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      req_type r;
      int      n;
      int      pick;

      // Directed plan. The table ends up holding, oldest first: a one-byte
      // region, a 64 GiB region, a 4 GiB region and a 68-byte region whose
      // last byte is the top of the address space.
      plan.push_back(plan_row(MODE_ALLOC, '0, '0, 32'd1, 1, STATUS_NO_ROOM, '0));
      plan.push_back(plan_row(MODE_ALLOC, '0, '0, 32'd0, 1, STATUS_BAD_ARG, '0));
      plan.push_back(plan_row(MODE_ADD, '0, 48'd100, '0, 1, STATUS_BAD_ARG, '0));
      plan.push_back(plan_row(MODE_ADD, 48'h1000, 48'd32, '0, 1, STATUS_BAD_ARG, '0));
      plan.push_back(plan_row(MODE_ADD, '1, 48'd2, '0, 1, STATUS_BAD_ARG, '0));
      plan.push_back(plan_row(MODE_ADD, '1, '1, '1, 1, STATUS_BAD_ARG, '0));
      plan.push_back(plan_row(MODE_ADD, 48'h1000, 48'd33, '0, 1, STATUS_OK, '0));
      plan.push_back(plan_row(MODE_ALLOC, '0, '0, 32'd2, 1, STATUS_NO_ROOM, '0));
      plan.push_back(plan_row(MODE_ALLOC, '0, '0, 32'd1, 1, STATUS_OK, 48'h1020));
      plan.push_back(plan_row(MODE_ALLOC, '0, '0, 32'd1, 1, STATUS_NO_ROOM, '0));
      // Allocate fields outside the size are ignored
      plan.push_back(plan_row(MODE_ALLOC, '1, '1, 32'd0, 1, STATUS_BAD_ARG, '0));
      plan.push_back(plan_row(MODE_ADD, 48'h2000_0000_0000, 48'h10_0000_0020, '0,
                              1, STATUS_OK, '0));
      plan.push_back(plan_row(MODE_ADD, 48'h10_0000_0000, 48'h1_0000_0020, '0,
                              1, STATUS_OK, '0));
      plan.push_back(plan_row(MODE_ALLOC, '0, '0, '1, 1, STATUS_OK, 48'h10_0000_0020));
      // Newest region one byte short: fall through to the older one
      plan.push_back(plan_row(MODE_ALLOC, '0, '0, 32'd2, 0, STATUS_OK, '0));
      plan.push_back(plan_row(MODE_ALLOC, '0, '0, 32'd1, 0, STATUS_OK, '0));
      plan.push_back(plan_row(MODE_ADD, 48'hFFFF_FFFF_FF9C, 48'd100, '0,
                              1, STATUS_OK, '0));
      // One byte past the top of the address space, table already full
      plan.push_back(plan_row(MODE_ADD, 48'hFFFF_FFFF_FF9C, 48'd101, '0,
                              1, STATUS_BAD_ARG, '0));
      plan.push_back(plan_row(MODE_ADD, 48'h3000, 48'h1000, '0, 1, STATUS_FULL, '0));
      plan.push_back(plan_row(MODE_ALLOC, '0, '0, 32'd68, 1, STATUS_OK,
                              48'hFFFF_FFFF_FFBC));
      plan.push_back(plan_row(MODE_ALLOC, '0, '0, 32'd1, 0, STATUS_OK, '0));
      plan.push_back(plan_row(MODE_ADD, 48'd1, 48'd33, '0, 1, STATUS_FULL, '0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[k])
         offer(plan[k].req, plan[k].fixed, plan[k].outcome);

      // Random part: mostly allocations with sizes spread over several
      // scales, so that the newer regions run dry and the search reaches
      // deeper; adds now test the argument checks against a full table
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         r.mode        = ($urandom_range(0, 99) < 85) ? MODE_ALLOC : MODE_ADD;
         r.region_base = ADDR_BITS'({$urandom(), $urandom()});
         r.region_len  = ADDR_BITS'({$urandom(), $urandom()});
         pick          = $urandom_range(0, 9);
         if (r.mode == MODE_ADD) begin
            if (pick < 2) r.region_base = '0;
            if (pick >= 2 && pick < 5)
               r.region_len = ADDR_BITS'($urandom_range(0, 2 * HEADER_BYTES));
         end
         case (pick)
            0, 1, 2, 3: r.alloc_size = $urandom_range(1, 64);
            4, 5, 6:    r.alloc_size = $urandom_range(1, 65535);
            7, 8:       r.alloc_size = $urandom_range(1, 1 << 28);
            default:    r.alloc_size = $urandom();
         endcase
         if ($urandom_range(0, 49) == 0) r.alloc_size = '0;

         // Hold off once until every outstanding result has come back
         if (n == RANDOM_ITEMS / 2) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (pending_outcomes.size() != 0);
         end
         offer(r, 1'b0, '0);
      end

      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
